@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bti_pkg.sv @@
// ----------------------------------------------------------------------------
// bti_pkg
// Types and fixed widths for the bilinear table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bti_pkg;

  // Value and arithmetic widths (values are signed Q16.16).
  localparam int VALUE_W = 32;
  localparam int DIFF_W  = VALUE_W + 1;
  localparam int OPND_W  = VALUE_W + 2;
  localparam int MUL_W   = 2 * OPND_W;
  localparam int PAIR_W  = 2 * DIFF_W;
  localparam int ACC_W   = 3 * VALUE_W + 8;
  localparam int NUM_W   = ACC_W + 2;
  localparam int QUO_W   = VALUE_W + 1;
  localparam int CNT_W   = 7;
  localparam int STEP_W  = 6;

  typedef enum logic [1:0] {
    ACT_LOAD_X    = 2'd0,
    ACT_LOAD_Y    = 2'd1,
    ACT_LOAD_GRID = 2'd2,
    ACT_EVAL      = 2'd3
  } action_t;

  typedef enum logic {
    CFG_X_COUNT = 1'b0,
    CFG_Y_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMP0, ST_CMPL, ST_CMPP, ST_DOWN, ST_UP, ST_RDLO, ST_RDHI,
    ST_GETHI, ST_GRID, ST_MUL, ST_ABS, ST_PREP, ST_CHK, ST_DIV, ST_FIN
  } state_t;

  typedef struct packed {
    action_t                   action;
    logic [5:0]                column;
    logic [5:0]                row;
    logic signed [VALUE_W-1:0] load_value;
    logic signed [VALUE_W-1:0] query_x;
    logic signed [VALUE_W-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result;
    logic                      x_below;
    logic                      x_above;
    logic                      y_below;
    logic                      y_above;
    logic                      saturated;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/bilinear_table_interpolation.sv @@
// ----------------------------------------------------------------------------
// bilinear_table_interpolation
// Two-dimensional breakpoint table with hunting search and exact, rounded
// bilinear interpolation, saturated to the value range.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_ready   bti_pkg::in_item_t
//  out_     output     out_valid/out_ready bti_pkg::out_item_t
//  cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// Loads go back to back; an evaluate blocks new items, and its time grows per
// interval stepped by the hunt on each axis; it is set by the one-read-per-
// cycle breakpoint memories, the shared 34x34 multiplier (14 steps) and the
// 33-step restoring divider. A zero cell area finishes after the multiplies.
// Reset is synchronous and active low; the tables are not cleared.
// A result waiting at the output stalls only the final step of the next one.
`default_nettype none
`include "assert_macros.svh"

module bilinear_table_interpolation #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bti_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bti_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [bti_pkg::CNT_W-1:0]     cfg_wdata
);

  localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int IW   = $clog2(MAXP);
  localparam int XIW  = $clog2(MAX_X_POINTS);
  localparam int YIW  = $clog2(MAX_Y_POINTS);
  localparam int GAW  = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
  localparam int VW   = bti_pkg::VALUE_W;

  // Storage.
  logic signed [VW-1:0] xmem [MAX_X_POINTS];
  logic signed [VW-1:0] ymem [MAX_Y_POINTS];
  logic signed [VW-1:0] gmem [MAX_X_POINTS * MAX_Y_POINTS];
  logic signed [VW-1:0] xrd_r, yrd_r, grd_r;

  // Control state.
  bti_pkg::state_t          state_r, state_nxt;
  logic                     ax_r, ax_nxt;
  logic [IW-1:0]            p_r, p_nxt;
  logic [IW-1:0]            hx_r, hy_r;
  logic [bti_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [bti_pkg::CNT_W-1:0]  xcnt_r, ycnt_r;
  logic                     out_valid_r;
  bti_pkg::out_item_t       out_data_r, fin_item;

  // Datapath.
  logic signed [VW-1:0]                 qx_r, qy_r, xlo_r, xhi_r, ylo_r, yhi_r;
  logic signed [VW-1:0]                 g_r [4];
  logic                                 xb_r, xa_r, yb_r, ya_r;
  logic signed [bti_pkg::DIFF_W-1:0]    dx0_r, dx1_r, dy0_r, dy1_r, ex_r, ey_r;
  logic signed [bti_pkg::OPND_W-1:0]    ma, mb;
  logic signed [bti_pkg::MUL_W-1:0]     mul_r, mul_nxt;
  logic signed [bti_pkg::PAIR_W-1:0]    pair_r, den_r;
  logic signed [bti_pkg::ACC_W-1:0]     acc_r;
  logic [bti_pkg::ACC_W-1:0]            an_r;
  logic [bti_pkg::PAIR_W-1:0]           dn_r;
  logic [bti_pkg::NUM_W-1:0]            num_r, dsh_r;
  logic [bti_pkg::QUO_W-1:0]            q_r;
  logic                                 neg_r, zero_r, ovf_r;

  // Combinational helpers.
  logic [IW-1:0]        rd_idx, last_x, last_y, last_idx, hunt, hunt_c, grow, gcol;
  logic [GAW-1:0]       ga;
  logic signed [VW-1:0] d, v;
  logic                 in_xfer, eval_xfer, fin_go;

  assign in_ready  = (state_r == bti_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign eval_xfer = in_xfer && (in_data.action == bti_pkg::ACT_EVAL);
  assign fin_go    = (state_r == bti_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Last usable breakpoint index per axis, with the count clamped.
  always_comb begin
    if (xcnt_r < bti_pkg::CNT_W'(2)) begin
      last_x = IW'(1);
    end else if (int'(xcnt_r) > MAX_X_POINTS) begin
      last_x = IW'(MAX_X_POINTS - 1);
    end else begin
      last_x = IW'(xcnt_r - bti_pkg::CNT_W'(1));
    end
    if (ycnt_r < bti_pkg::CNT_W'(2)) begin
      last_y = IW'(1);
    end else if (int'(ycnt_r) > MAX_Y_POINTS) begin
      last_y = IW'(MAX_Y_POINTS - 1);
    end else begin
      last_y = IW'(ycnt_r - bti_pkg::CNT_W'(1));
    end
  end

  // Per-axis view of the search.
  assign d        = ax_r ? yrd_r : xrd_r;
  assign v        = ax_r ? qy_r : qx_r;
  assign last_idx = ax_r ? last_y : last_x;
  assign hunt     = ax_r ? hy_r : hx_r;

  always_comb begin
    if (hunt < IW'(1)) begin
      hunt_c = IW'(1);
    end else if (hunt > last_idx) begin
      hunt_c = last_idx;
    end else begin
      hunt_c = hunt;
    end
  end

  // Grid corner address: bit 1 of the step picks the row, bit 0 the column.
  assign grow = step_r[1] ? hy_r : hy_r - IW'(1);
  assign gcol = step_r[0] ? hx_r : hx_r - IW'(1);
  assign ga   = GAW'(GAW'(grow) * GAW'(MAX_X_POINTS)) + GAW'(gcol);

  // Next state, read index and step counter.
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    p_nxt     = p_r;
    step_nxt  = step_r;
    rd_idx    = p_r;
    case (state_r)
      bti_pkg::ST_IDLE: begin
        if (eval_xfer) begin
          rd_idx    = '0;
          ax_nxt    = 1'b0;
          state_nxt = bti_pkg::ST_CMP0;
        end
      end
      bti_pkg::ST_CMP0: begin
        if (v <= d) begin
          p_nxt     = IW'(1);
          state_nxt = bti_pkg::ST_RDLO;
        end else begin
          rd_idx    = last_idx;
          state_nxt = bti_pkg::ST_CMPL;
        end
      end
      bti_pkg::ST_CMPL: begin
        if (v >= d) begin
          p_nxt     = last_idx;
          state_nxt = bti_pkg::ST_RDLO;
        end else begin
          p_nxt     = hunt_c;
          rd_idx    = hunt_c;
          state_nxt = bti_pkg::ST_CMPP;
        end
      end
      bti_pkg::ST_CMPP: begin
        state_nxt = bti_pkg::ST_RDLO;
        if (v < d) begin
          if (p_r > IW'(1)) begin
            rd_idx    = p_r - IW'(1);
            state_nxt = bti_pkg::ST_DOWN;
          end
        end else if (v > d) begin
          if (p_r < last_idx) begin
            p_nxt     = p_r + IW'(1);
            rd_idx    = p_r + IW'(1);
            state_nxt = bti_pkg::ST_UP;
          end
        end
      end
      bti_pkg::ST_DOWN: begin
        // d holds the breakpoint just below p.
        state_nxt = bti_pkg::ST_RDLO;
        if (v < d) begin
          p_nxt = p_r - IW'(1);
          if (p_r - IW'(1) > IW'(1)) begin
            rd_idx    = p_r - IW'(2);
            state_nxt = bti_pkg::ST_DOWN;
          end
        end
      end
      bti_pkg::ST_UP: begin
        // d holds the breakpoint at p.
        state_nxt = bti_pkg::ST_RDLO;
        if (p_r < last_idx && v > d) begin
          p_nxt     = p_r + IW'(1);
          rd_idx    = p_r + IW'(1);
          state_nxt = bti_pkg::ST_UP;
        end
      end
      bti_pkg::ST_RDLO: begin
        rd_idx    = p_r - IW'(1);
        state_nxt = bti_pkg::ST_RDHI;
      end
      bti_pkg::ST_RDHI: begin
        rd_idx    = p_r;
        state_nxt = bti_pkg::ST_GETHI;
      end
      bti_pkg::ST_GETHI: begin
        if (!ax_r) begin
          ax_nxt    = 1'b1;
          rd_idx    = '0;
          state_nxt = bti_pkg::ST_CMP0;
        end else begin
          step_nxt  = '0;
          state_nxt = bti_pkg::ST_GRID;
        end
      end
      bti_pkg::ST_GRID: begin
        if (step_r == bti_pkg::STEP_W'(4)) begin
          step_nxt  = '0;
          state_nxt = bti_pkg::ST_MUL;
        end else begin
          step_nxt = step_r + bti_pkg::STEP_W'(1);
        end
      end
      bti_pkg::ST_MUL: begin
        if (step_r == bti_pkg::STEP_W'(13)) begin
          state_nxt = bti_pkg::ST_ABS;
        end else begin
          step_nxt = step_r + bti_pkg::STEP_W'(1);
        end
      end
      bti_pkg::ST_ABS: begin
        state_nxt = (den_r == '0) ? bti_pkg::ST_FIN : bti_pkg::ST_PREP;
      end
      bti_pkg::ST_PREP: begin
        state_nxt = bti_pkg::ST_CHK;
      end
      bti_pkg::ST_CHK: begin
        step_nxt  = '0;
        state_nxt = (num_r >= (dsh_r << 1)) ? bti_pkg::ST_FIN : bti_pkg::ST_DIV;
      end
      bti_pkg::ST_DIV: begin
        if (step_r == bti_pkg::STEP_W'(bti_pkg::QUO_W - 1)) begin
          state_nxt = bti_pkg::ST_FIN;
        end else begin
          step_nxt = step_r + bti_pkg::STEP_W'(1);
        end
      end
      bti_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = bti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bti_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bti_pkg::ST_IDLE;
      ax_r        <= 1'b0;
      step_r      <= '0;
      hx_r        <= '0;
      hy_r        <= '0;
      xcnt_r      <= bti_pkg::CNT_W'(2);
      ycnt_r      <= bti_pkg::CNT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      step_r  <= step_nxt;
      if (state_r == bti_pkg::ST_RDLO) begin
        if (ax_r) begin
          hy_r <= p_r;
        end else begin
          hx_r <= p_r;
        end
      end
      if (cfg_we) begin
        case (bti_pkg::cfg_idx_t'(cfg_index))
          bti_pkg::CFG_X_COUNT: xcnt_r <= cfg_wdata;
          bti_pkg::CFG_Y_COUNT: ycnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Breakpoint and grid memories: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == bti_pkg::ACT_LOAD_X &&
        int'(in_data.column) < MAX_X_POINTS) begin
      xmem[XIW'(in_data.column)] <= in_data.load_value;
    end
    xrd_r <= xmem[rd_idx[XIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == bti_pkg::ACT_LOAD_Y &&
        int'(in_data.row) < MAX_Y_POINTS) begin
      ymem[YIW'(in_data.row)] <= in_data.load_value;
    end
    yrd_r <= ymem[rd_idx[YIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == bti_pkg::ACT_LOAD_GRID &&
        int'(in_data.column) < MAX_X_POINTS && int'(in_data.row) < MAX_Y_POINTS) begin
      gmem[GAW'(GAW'(in_data.row) * GAW'(MAX_X_POINTS)) + GAW'(in_data.column)]
        <= in_data.load_value;
    end
    grd_r <= gmem[ga];
  end

  // Shared multiplier operands. Each corner weight (a 66-bit product) is
  // multiplied by its grid value in two halves: low 33 bits, then high.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      bti_pkg::STEP_W'(0):  begin ma = bti_pkg::OPND_W'(ex_r);  mb = bti_pkg::OPND_W'(ey_r);  end
      bti_pkg::STEP_W'(1):  begin ma = bti_pkg::OPND_W'(dx1_r); mb = bti_pkg::OPND_W'(dy1_r); end
      bti_pkg::STEP_W'(4):  begin ma = bti_pkg::OPND_W'(dx0_r); mb = bti_pkg::OPND_W'(dy1_r); end
      bti_pkg::STEP_W'(7):  begin ma = bti_pkg::OPND_W'(dx1_r); mb = bti_pkg::OPND_W'(dy0_r); end
      bti_pkg::STEP_W'(10): begin ma = bti_pkg::OPND_W'(dx0_r); mb = bti_pkg::OPND_W'(dy0_r); end
      bti_pkg::STEP_W'(2), bti_pkg::STEP_W'(5),
      bti_pkg::STEP_W'(8), bti_pkg::STEP_W'(11): begin
        ma = $signed({1'b0, mul_r[bti_pkg::DIFF_W-1:0]});
      end
      bti_pkg::STEP_W'(3), bti_pkg::STEP_W'(6),
      bti_pkg::STEP_W'(9), bti_pkg::STEP_W'(12): begin
        ma = bti_pkg::OPND_W'($signed(pair_r[bti_pkg::PAIR_W-1:bti_pkg::DIFF_W]));
      end
      default: ;
    endcase
    case (step_r)
      bti_pkg::STEP_W'(2),  bti_pkg::STEP_W'(3):  mb = bti_pkg::OPND_W'(g_r[0]);
      bti_pkg::STEP_W'(5),  bti_pkg::STEP_W'(6):  mb = bti_pkg::OPND_W'(g_r[1]);
      bti_pkg::STEP_W'(8),  bti_pkg::STEP_W'(9):  mb = bti_pkg::OPND_W'(g_r[2]);
      bti_pkg::STEP_W'(11), bti_pkg::STEP_W'(12): mb = bti_pkg::OPND_W'(g_r[3]);
      default: ;
    endcase
  end

  assign mul_nxt = ma * mb;

  // Sign and saturation of the quotient, or the lower corner for a zero cell area.
  always_comb begin
    fin_item         = '0;
    fin_item.x_below = xb_r;
    fin_item.x_above = xa_r;
    fin_item.y_below = yb_r;
    fin_item.y_above = ya_r;
    if (zero_r) begin
      fin_item.result = g_r[0];
    end else if (ovf_r) begin
      fin_item.saturated = 1'b1;
      fin_item.result    = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else if (neg_r) begin
      if (q_r > (bti_pkg::QUO_W'(1) << (VW - 1))) begin
        fin_item.saturated = 1'b1;
        fin_item.result    = {1'b1, {(VW-1){1'b0}}};
      end else begin
        fin_item.result = VW'(-q_r);
      end
    end else begin
      if (q_r[bti_pkg::QUO_W-1:VW-1] != '0) begin
        fin_item.saturated = 1'b1;
        fin_item.result    = {1'b0, {(VW-1){1'b1}}};
      end else begin
        fin_item.result = VW'(q_r);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (eval_xfer) begin
      qx_r <= in_data.query_x;
      qy_r <= in_data.query_y;
    end
    case (state_r)
      bti_pkg::ST_CMP0: begin
        if (ax_r) begin
          yb_r <= (v <= d);
          ya_r <= 1'b0;
        end else begin
          xb_r <= (v <= d);
          xa_r <= 1'b0;
        end
      end
      bti_pkg::ST_CMPL: begin
        if (ax_r) begin
          ya_r <= (v >= d);
        end else begin
          xa_r <= (v >= d);
        end
      end
      bti_pkg::ST_RDHI: begin
        if (ax_r) begin
          ylo_r <= d;
        end else begin
          xlo_r <= d;
        end
      end
      bti_pkg::ST_GETHI: begin
        if (ax_r) begin
          yhi_r <= d;
        end else begin
          xhi_r <= d;
        end
      end
      bti_pkg::ST_GRID: begin
        if (step_r == '0) begin
          dx0_r <= bti_pkg::DIFF_W'(qx_r) - bti_pkg::DIFF_W'(xlo_r);
          dx1_r <= bti_pkg::DIFF_W'(xhi_r) - bti_pkg::DIFF_W'(qx_r);
          dy0_r <= bti_pkg::DIFF_W'(qy_r) - bti_pkg::DIFF_W'(ylo_r);
          dy1_r <= bti_pkg::DIFF_W'(yhi_r) - bti_pkg::DIFF_W'(qy_r);
          ex_r  <= bti_pkg::DIFF_W'(xhi_r) - bti_pkg::DIFF_W'(xlo_r);
          ey_r  <= bti_pkg::DIFF_W'(yhi_r) - bti_pkg::DIFF_W'(ylo_r);
        end else begin
          g_r[step_r[1:0] - 2'd1] <= grd_r;
        end
      end
      bti_pkg::ST_MUL: begin
        mul_r <= mul_nxt;
        case (step_r)
          bti_pkg::STEP_W'(0): acc_r <= '0;
          bti_pkg::STEP_W'(1): den_r <= mul_r[bti_pkg::PAIR_W-1:0];
          bti_pkg::STEP_W'(2), bti_pkg::STEP_W'(5),
          bti_pkg::STEP_W'(8), bti_pkg::STEP_W'(11): begin
            pair_r <= mul_r[bti_pkg::PAIR_W-1:0];
          end
          bti_pkg::STEP_W'(3), bti_pkg::STEP_W'(6),
          bti_pkg::STEP_W'(9), bti_pkg::STEP_W'(12): begin
            acc_r <= acc_r + bti_pkg::ACC_W'(mul_r);
          end
          bti_pkg::STEP_W'(4), bti_pkg::STEP_W'(7),
          bti_pkg::STEP_W'(10), bti_pkg::STEP_W'(13): begin
            acc_r <= acc_r + (bti_pkg::ACC_W'(mul_r) <<< bti_pkg::DIFF_W);
          end
          default: ;
        endcase
      end
      bti_pkg::ST_ABS: begin
        zero_r <= (den_r == '0);
        ovf_r  <= 1'b0;
        neg_r  <= acc_r[bti_pkg::ACC_W-1] ^ den_r[bti_pkg::PAIR_W-1];
        an_r   <= acc_r[bti_pkg::ACC_W-1] ? bti_pkg::ACC_W'(-acc_r) : bti_pkg::ACC_W'(acc_r);
        dn_r   <= den_r[bti_pkg::PAIR_W-1] ? bti_pkg::PAIR_W'(-den_r)
                                           : bti_pkg::PAIR_W'(den_r);
      end
      bti_pkg::ST_PREP: begin
        // Round half away from zero: (2|N| + |D|) / (2|D|).
        num_r <= (bti_pkg::NUM_W'(an_r) << 1) + bti_pkg::NUM_W'(dn_r);
        dsh_r <= bti_pkg::NUM_W'(dn_r) << bti_pkg::QUO_W;
      end
      bti_pkg::ST_CHK: begin
        ovf_r <= (num_r >= (dsh_r << 1));
        q_r   <= '0;
      end
      bti_pkg::ST_DIV: begin
        if (num_r >= dsh_r) begin
          num_r <= num_r - dsh_r;
          q_r   <= {q_r[bti_pkg::QUO_W-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[bti_pkg::QUO_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      default: ;
    endcase
    if (fin_go) begin
      out_data_r <= fin_item;
    end
  end

  // Checks.
  `ASSERT_SAME(a_flags_excl, clk, rst_n, out_valid_r,
    !(out_data_r.x_below && out_data_r.x_above) &&
    !(out_data_r.y_below && out_data_r.y_above), "below and above both set")
  `ASSERT_SAME(a_sat_limit, clk, rst_n, out_valid_r && out_data_r.saturated,
    out_data_r.result == {1'b1, {(VW-1){1'b0}}} ||
    out_data_r.result == {1'b0, {(VW-1){1'b1}}}, "saturated result not at a limit")
  `ASSERT_NEXT(a_eval_busy, clk, rst_n, eval_xfer, !in_ready,
    "input taken while an evaluate is in progress")

endmodule

`default_nettype wire

@@ test/tb_bilinear_table_interpolation.sv @@
// ----------------------------------------------------------------------------
// tb_bilinear_table_interpolation
// Self-checking bench for the bilinear table interpolator. Tables are filled
// by load transfers, evaluations are predicted with exact wide arithmetic and
// every result is checked in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_bilinear_table_interpolation;

  typedef logic signed [bti_pkg::VALUE_W-1:0] val_t;
  typedef logic signed [191:0]                wide_t;

  localparam int MAX_PTS = 64;
  localparam int SETTLE  = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bti_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  bti_pkg::out_item_t out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [bti_pkg::CNT_W-1:0] cfg_wdata;

  bilinear_table_interpolation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the tables, counts and hunt positions.
  val_t x_points [MAX_PTS];
  val_t y_points [MAX_PTS];
  val_t grid_mem [MAX_PTS][MAX_PTS];
  int   x_count_raw;
  int   y_count_raw;
  int   x_hunt;
  int   y_hunt;

  bti_pkg::out_item_t pending_results[$];
  int                 mismatches;
  bit                 quiet_sender;
  int                 hold_request;
  int                 eval_kind;

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_count(input int c);
    if (c < 2) return 2;
    if (c > MAX_PTS) return MAX_PTS;
    return c;
  endfunction

  // Interval search that starts from the last interval found.
  function automatic int hunt_interval(input val_t tab[MAX_PTS], input int cnt, input val_t v,
                                       inout int h, output bit below, output bit above);
    int p;
    below = 1'b0;
    above = 1'b0;
    if (v <= tab[0]) begin
      below = 1'b1;
      p = 1;
    end else if (v >= tab[cnt-1]) begin
      above = 1'b1;
      p = cnt - 1;
    end else begin
      p = h;
      if (p < 1) p = 1;
      if (p > cnt - 1) p = cnt - 1;
      if (v < tab[p]) begin
        while (p > 1 && v < tab[p-1]) p--;
      end else if (v > tab[p]) begin
        while (p < cnt - 1 && v > tab[p]) p++;
      end
    end
    h = p;
    return p;
  endfunction

  // Applies one transfer to the shadow state; returns 1 with the expected
  // result for an evaluation.
  function automatic bit interpolate(input bti_pkg::in_item_t it,
                                     output bti_pkg::out_item_t r);
    int    ix1, iy1;
    bit    xb, xa, yb, ya, neg;
    wide_t xd0, xd1, yd0, yd1, num, den, q;
    val_t  x0, x1, y0, y1;
    r = '0;
    case (it.action)
      bti_pkg::ACT_LOAD_X: begin
        x_points[it.column] = it.load_value;
        return 1'b0;
      end
      bti_pkg::ACT_LOAD_Y: begin
        y_points[it.row] = it.load_value;
        return 1'b0;
      end
      bti_pkg::ACT_LOAD_GRID: begin
        grid_mem[it.row][it.column] = it.load_value;
        return 1'b0;
      end
      default: begin
        ix1 = hunt_interval(x_points, clamp_count(x_count_raw), it.query_x, x_hunt, xb, xa);
        iy1 = hunt_interval(y_points, clamp_count(y_count_raw), it.query_y, y_hunt, yb, ya);
        x0 = x_points[ix1-1];
        x1 = x_points[ix1];
        y0 = y_points[iy1-1];
        y1 = y_points[iy1];
        xd0 = wide_t'(it.query_x) - wide_t'(x0);
        xd1 = wide_t'(x1) - wide_t'(it.query_x);
        yd0 = wide_t'(it.query_y) - wide_t'(y0);
        yd1 = wide_t'(y1) - wide_t'(it.query_y);
        den = (wide_t'(x1) - wide_t'(x0)) * (wide_t'(y1) - wide_t'(y0));
        r.x_below = xb;
        r.x_above = xa;
        r.y_below = yb;
        r.y_above = ya;
        if (den == 0) begin
          // Degenerate cell: the lower corner is returned as it is.
          r.result = grid_mem[iy1-1][ix1-1];
        end else begin
          num = wide_t'(grid_mem[iy1-1][ix1-1]) * xd1 * yd1
              + wide_t'(grid_mem[iy1-1][ix1])   * xd0 * yd1
              + wide_t'(grid_mem[iy1][ix1-1])   * xd1 * yd0
              + wide_t'(grid_mem[iy1][ix1])     * xd0 * yd0;
          neg = (num < 0) ^ (den < 0);
          if (num < 0) num = -num;
          if (den < 0) den = -den;
          // Round half away from zero on the magnitudes.
          q = (2 * num + den) / (2 * den);
          if (neg) begin
            if (q > 64'sh8000_0000) begin
              r.saturated = 1'b1;
              q = 64'sh8000_0000;
            end
            r.result = val_t'(-q);
          end else begin
            if (q > 64'sh7FFF_FFFF) begin
              r.saturated = 1'b1;
              q = 64'sh7FFF_FFFF;
            end
            r.result = val_t'(q);
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(90, 20);
  endfunction

  // Sends one item and records what it should produce once it is taken.
  task automatic send_item(input bti_pkg::in_item_t it);
    int                 gap;
    bti_pkg::out_item_t r;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (interpolate(it, r)) pending_results.push_back(r);
  endtask

  function automatic bti_pkg::in_item_t random_item(input bti_pkg::action_t act);
    bti_pkg::in_item_t it;
    it.action     = act;
    it.column     = 6'($urandom);
    it.row        = 6'($urandom);
    it.load_value = val_t'($urandom);
    it.query_x    = val_t'($urandom);
    it.query_y    = val_t'($urandom);
    return it;
  endfunction

  task automatic load_value(input bti_pkg::action_t act, input int col, input int row,
                            input val_t v);
    bti_pkg::in_item_t it;
    it            = random_item(act);
    it.column     = 6'(col);
    it.row        = 6'(row);
    it.load_value = v;
    send_item(it);
  endtask

  task automatic evaluate(input val_t qx, input val_t qy);
    bti_pkg::in_item_t it;
    it         = random_item(bti_pkg::ACT_EVAL);
    it.query_x = qx;
    it.query_y = qy;
    send_item(it);
  endtask

  // Stops sending, waits for every expected result, then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_counts(input int xc, input int yc);
    cfg_we    <= 1'b1;
    cfg_index <= bti_pkg::CFG_X_COUNT;
    cfg_wdata <= bti_pkg::CNT_W'(xc);
    @(posedge clk);
    cfg_index <= bti_pkg::CFG_Y_COUNT;
    cfg_wdata <= bti_pkg::CNT_W'(yc);
    @(posedge clk);
    cfg_we <= 1'b0;
    x_count_raw = xc;
    y_count_raw = yc;
  endtask

  // Axis value for point i of cnt. Kind 0: narrow and increasing, 1: wide and
  // increasing, 2: arbitrary order, 3: increasing with repeated neighbours.
  function automatic val_t axis_point(input int kind, input int i, input int cnt, input val_t prev);
    longint v;
    case (kind)
      0: v = (i == 0) ? longint'($urandom_range(2_000_000)) - 1_000_000
                      : longint'(prev) + $urandom_range(262_144, 1);
      1: v = -64'sd2147483648 + longint'(i) * (64'sd4294967296 / cnt)
             + $urandom_range(33_554_431);
      2: v = longint'(val_t'($urandom));
      default: v = (i == 0) ? 64'sd0
                 : longint'(prev) + (($urandom_range(2) == 0) ? 0 : $urandom_range(131_072, 1));
    endcase
    return val_t'(v);
  endfunction

  function automatic val_t grid_value();
    case ($urandom_range(3))
      0:       return val_t'($urandom);
      1:       return ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return val_t'(int'($urandom_range(2_000_000)) - 1_000_000);
    endcase
  endfunction

  // Writes every breakpoint and grid entry that the current counts reach.
  task automatic fill_table(input int kind);
    int   cx, cy;
    val_t prev;
    cx = clamp_count(x_count_raw);
    cy = clamp_count(y_count_raw);
    prev = '0;
    for (int i = 0; i < cx; i++) begin
      prev = axis_point(kind, i, cx, prev);
      load_value(bti_pkg::ACT_LOAD_X, i, $urandom_range(63), prev);
    end
    for (int i = 0; i < cy; i++) begin
      prev = axis_point(kind, i, cy, prev);
      load_value(bti_pkg::ACT_LOAD_Y, $urandom_range(63), i, prev);
    end
    for (int r = 0; r < cy; r++)
      for (int c = 0; c < cx; c++) load_value(bti_pkg::ACT_LOAD_GRID, c, r, grid_value());
  endtask

  // A coordinate near the used part of an axis, on a breakpoint, or anywhere.
  function automatic val_t pick_query(input val_t tab[MAX_PTS], input int cnt);
    longint lo, hi, span, v;
    int     m;
    m = $urandom_range(9);
    if (m < 2) return val_t'($urandom);
    if (m < 3) return tab[$urandom_range(cnt - 1)];
    lo = tab[0];
    hi = tab[cnt-1];
    if (hi < lo) begin
      v = lo;
      lo = hi;
      hi = v;
    end
    span = hi - lo + 1;
    v = lo - span / 8 + longint'({$urandom, $urandom} % (span + span / 4 + 1));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return val_t'(v);
  endfunction

  // Random run: mostly evaluations, some grid reloads inside the table and a
  // few breakpoint loads anywhere.
  task automatic random_traffic(input int evals);
    int                cx, cy, r;
    bti_pkg::in_item_t it;
    cx = clamp_count(x_count_raw);
    cy = clamp_count(y_count_raw);
    for (int n = 0; n < evals; ) begin
      r = $urandom_range(99);
      if (r < 80) begin
        evaluate(pick_query(x_points, cx), pick_query(y_points, cy));
        n++;
      end else if (r < 95) begin
        load_value(bti_pkg::ACT_LOAD_GRID, $urandom_range(cx - 1), $urandom_range(cy - 1),
                   grid_value());
      end else begin
        it = random_item(($urandom_range(1) == 1) ? bti_pkg::ACT_LOAD_X
                                                  : bti_pkg::ACT_LOAD_Y);
        send_item(it);
      end
    end
  endtask

  // Corners, edges, extremes, saturation both ways, a flat cell and a
  // falling axis on the smallest table.
  task automatic test_directed();
    load_value(bti_pkg::ACT_LOAD_X, 0, 0, 32'sh0000_0000);
    load_value(bti_pkg::ACT_LOAD_X, 1, 63, 32'sh0001_0000);
    load_value(bti_pkg::ACT_LOAD_Y, 63, 0, 32'sh0000_0000);
    load_value(bti_pkg::ACT_LOAD_Y, 0, 1, 32'sh0002_0000);
    load_value(bti_pkg::ACT_LOAD_GRID, 0, 0, 32'sh0000_0000);
    load_value(bti_pkg::ACT_LOAD_GRID, 1, 0, 32'sh0001_0000);
    load_value(bti_pkg::ACT_LOAD_GRID, 0, 1, 32'sh0002_0000);
    load_value(bti_pkg::ACT_LOAD_GRID, 1, 1, 32'sh7FFF_FFFF);
    load_value(bti_pkg::ACT_LOAD_GRID, 63, 63, 32'sh8000_0000);
    evaluate(32'sh0000_0000, 32'sh0000_0000);
    evaluate(32'sh0000_8000, 32'sh0001_0000);
    evaluate(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    evaluate(32'sh8000_0000, 32'sh8000_0000);
    evaluate(32'sh0001_0000, 32'sh0002_0000);
    evaluate(32'sh0000_0001, 32'sh0001_FFFF);
    load_value(bti_pkg::ACT_LOAD_GRID, 1, 1, 32'sh8000_0000);
    evaluate(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    evaluate(32'sh7FFF_FFFF, 32'sh8000_0000);
    // Equal breakpoints give a cell of zero area.
    load_value(bti_pkg::ACT_LOAD_X, 1, 0, 32'sh0000_0000);
    evaluate(32'sh0000_4000, 32'sh0000_4000);
    // Falling axis.
    load_value(bti_pkg::ACT_LOAD_X, 1, 0, -32'sh0001_0000);
    evaluate(-32'sh0000_8000, 32'sh0001_0000);
    evaluate(32'sh0000_8000, 32'sh0001_0000);
    wait_idle();
  endtask

  // Several table sizes, with counts outside the legal range among them.
  task automatic test_table_sizes();
    int xs[9]    = '{127, 3,  0,  64, 2,  3,  8,  5,  16};
    int ys[9]    = '{2,   5,  1,  2,  65, 7,  4,  3,  2};
    int kinds[9] = '{1,   0,  1,  0,  1,  0,  2,  3,  1};
    int evals[9] = '{50,  50, 30, 30, 30, 30, 40, 30, 30};
    for (int s = 0; s < 9; s++) begin
      write_counts(xs[s], ys[s]);
      fill_table(kinds[s]);
      quiet_sender = (s == 3);
      random_traffic(evals[s]);
      quiet_sender = 1'b0;
      wait_idle();
    end
  endtask

  // The receiver holds off while the sender keeps offering evaluations.
  task automatic test_backpressure();
    write_counts(6, 6);
    fill_table(0);
    @(negedge clk);
    hold_request = 600;
    @(posedge clk);
    quiet_sender = 1'b1;
    random_traffic(30);
    quiet_sender = 1'b0;
    wait_idle();
  endtask

  // Ready handling on the result side, with long hold-offs on request.
  always @(posedge clk) begin
    int r;
    if (hold_request > 0) begin
      out_ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      r = $urandom_range(99);
      out_ready <= (r < 70) || (eval_kind == 1);
      if (r == 0) hold_request <= $urandom_range(60, 10);
    end
  end

  // Result check on every transfer at the output.
  always @(posedge clk) begin
    bti_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected result %h flags %b%b%b%b sat %b, got %h %b%b%b%b sat %b",
                     want.result, want.x_below, want.x_above, want.y_below, want.y_above,
                     want.saturated, out_data.result, out_data.x_below, out_data.x_above,
                     out_data.y_below, out_data.y_above, out_data.saturated);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = bti_pkg::CFG_X_COUNT;
    cfg_wdata    = '0;
    mismatches   = 0;
    quiet_sender = 1'b0;
    hold_request = 0;
    eval_kind    = 0;
    x_count_raw  = 2;
    y_count_raw  = 2;
    x_hunt       = 0;
    y_hunt       = 0;
    for (int i = 0; i < MAX_PTS; i++) begin
      x_points[i] = '0;
      y_points[i] = '0;
      for (int j = 0; j < MAX_PTS; j++) grid_mem[i][j] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_sizes();
    test_backpressure();
    wait_idle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
